// ===== sv/chss_pkg.sv =====
package chss_pkg;

    // Datapath widths: inputs carry 32 fraction bits, with room for CORDIC gain
    localparam int XW        = 52;
    localparam int ZW        = 42;
    localparam int FRAC_BITS = 32;

    typedef logic signed [XW-1:0] t_axis;
    typedef logic signed [ZW-1:0] t_angle;
    typedef logic [8:0]           t_deg;

    localparam t_deg FULL_TURN_DEG = 9'd360;

    localparam logic [63:0] Q46_ONE   = 64'd1 << 46;
    localparam logic [63:0] PI4_Q46   = 64'h00C9_0FDA_A221_68C2 >> 10;
    localparam logic [63:0] SCALE_NUM = 64'd75000;
    localparam logic [63:0] SCALE_DEN = 64'd1309;

    // Reciprocal of ten for values below 1024: floor(d * 205 / 2048)
    localparam logic [7:0] RECIP10      = 8'd205;
    localparam int         RECIP10_SHFT = 11;

    // Series term divided by the odd number 2k+1
    function automatic logic [63:0] div_odd(input logic [63:0] t, input int k);
        logic [63:0] q;
        case (k)
            0:  q = t;
            1:  q = t / 3;
            2:  q = t / 5;
            3:  q = t / 7;
            4:  q = t / 9;
            5:  q = t / 11;
            6:  q = t / 13;
            7:  q = t / 15;
            8:  q = t / 17;
            9:  q = t / 19;
            10: q = t / 21;
            11: q = t / 23;
            12: q = t / 25;
            13: q = t / 27;
            14: q = t / 29;
            15: q = t / 31;
            16: q = t / 33;
            17: q = t / 35;
            18: q = t / 37;
            19: q = t / 39;
            20: q = t / 41;
            21: q = t / 43;
            22: q = t / 45;
            default: q = 64'd0;
        endcase
        return q;
    endfunction

    // atan(2^-i) in Q46 radians, alternating series with truncated terms
    function automatic logic [63:0] atan_pow2_q46(input int i);
        logic [63:0] sum;
        logic [63:0] term;
        int          sh;
        sum = 64'd0;
        if (i == 0) begin
            sum = PI4_Q46;
        end else begin
            for (int k = 0; k < 64; k++) begin
                sh = i * (2 * k + 1);
                if (sh <= 46) begin
                    term = div_odd(Q46_ONE >> sh, k);
                    if (k % 2 == 1) begin
                        sum = sum - term;
                    end else begin
                        sum = sum + term;
                    end
                end
            end
        end
        return sum;
    endfunction

    // Q46 radians to Q32 scaled degrees, rounded
    function automatic logic [63:0] to_q32(input logic [63:0] q46_rad);
        logic [63:0] scaled;
        scaled = (q46_rad * SCALE_NUM) / SCALE_DEN;
        return (scaled + (64'd1 << 13)) >> 14;
    endfunction

    function automatic t_angle step_angle(input int i);
        logic [63:0] v;
        v = to_q32(atan_pow2_q46(i));
        return v[ZW-1:0];
    endfunction

    function automatic t_angle half_turn_q32();
        logic [63:0] v;
        v = to_q32(PI4_Q46 << 2);
        return v[ZW-1:0];
    endfunction

    localparam t_angle HALF_TURN = half_turn_q32();

    // Active-low segments, bit0 = A .. bit6 = G
    function automatic logic [6:0] digit_to_segments(input logic [3:0] digit);
        logic [6:0] seg;
        case (digit)
            4'd0:    seg = 7'h40;
            4'd1:    seg = 7'h79;
            4'd2:    seg = 7'h24;
            4'd3:    seg = 7'h30;
            4'd4:    seg = 7'h19;
            4'd5:    seg = 7'h12;
            4'd6:    seg = 7'h02;
            4'd7:    seg = 7'h78;
            4'd8:    seg = 7'h00;
            4'd9:    seg = 7'h10;
            default: seg = 7'h7F;
        endcase
        return seg;
    endfunction

endpackage

// ===== sv/compass_heading_seven_segment.sv =====
// Each sample passes through one fold stage, one register per CORDIC micro-rotation,
//   and the degree and digit stages before its o_strobe cycle.
// Throughput: one sample per cycle; each micro-rotation has its own adder stage.
// busy is low whenever reset is released, and the receiver cannot stall.
// Reset (synchronous, active low) clears every stage valid bit; payload is not reset.
module compass_heading_seven_segment
    import chss_pkg::*;
#(
    parameter int ANGLE_STEPS = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [15:0]  i_mag_x,
    input  logic signed [15:0]  i_mag_y,
    output logic                o_strobe,
    output logic [8:0]          o_heading_deg,
    output logic [6:0]          o_digit_segments
);

    logic   accept;

    t_axis  r_x    [0:ANGLE_STEPS];
    t_axis  r_y    [0:ANGLE_STEPS];
    t_angle r_z    [0:ANGLE_STEPS];
    logic   r_zero [0:ANGLE_STEPS];
    logic   r_vld  [0:ANGLE_STEPS];

    logic signed [16:0] xs;
    logic signed [16:0] ys;
    logic signed [16:0] xf;
    logic signed [16:0] yf;
    t_axis  n_x0;
    t_axis  n_y0;
    t_angle n_z0;
    logic   n_zero0;

    t_angle zmag;
    logic [8:0] mag;
    t_deg   n_deg;
    t_deg   r_deg;
    logic   r_deg_vld;

    logic [16:0] prod;
    logic [5:0]  quot;
    logic [8:0]  quot10;
    logic [3:0]  digit;

    assign busy   = !i_rst_n;
    assign accept = start && !busy;

    // Fold the left half plane onto the right one
    always_comb begin
        xs      = {i_mag_x[15], i_mag_x};
        ys      = {i_mag_y[15], i_mag_y};
        n_zero0 = (i_mag_x == 16'sd0) && (i_mag_y == 16'sd0);
        if (i_mag_x[15]) begin
            xf   = -xs;
            yf   = -ys;
            n_z0 = i_mag_y[15] ? -HALF_TURN : HALF_TURN;
        end else begin
            xf   = xs;
            yf   = ys;
            n_z0 = '0;
        end
        n_x0 = {{(XW-17-FRAC_BITS){xf[16]}}, xf, {FRAC_BITS{1'b0}}};
        n_y0 = {{(XW-17-FRAC_BITS){yf[16]}}, yf, {FRAC_BITS{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= accept;
        end
        r_x[0]    <= n_x0;
        r_y[0]    <= n_y0;
        r_z[0]    <= n_z0;
        r_zero[0] <= n_zero0;
    end

    for (genvar i = 0; i < ANGLE_STEPS; i++) begin : g_rot
        localparam t_angle STEP = step_angle(i);
        t_axis  dx;
        t_axis  dy;
        t_axis  n_x;
        t_axis  n_y;
        t_angle n_z;

        always_comb begin
            dx = r_y[i] >>> i;
            dy = r_x[i] >>> i;
            if (!r_y[i][XW-1]) begin
                n_x = r_x[i] + dx;
                n_y = r_y[i] - dy;
                n_z = r_z[i] + STEP;
            end else begin
                n_x = r_x[i] - dx;
                n_y = r_y[i] + dy;
                n_z = r_z[i] - STEP;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i+1] <= 1'b0;
            end else begin
                r_vld[i+1] <= r_vld[i];
            end
            r_x[i+1]    <= n_x;
            r_y[i+1]    <= n_y;
            r_z[i+1]    <= n_z;
            r_zero[i+1] <= r_zero[i];
        end
    end

    // Truncate toward zero, then move nonpositive headings up by a full turn; a zero field reads as a full turn
    always_comb begin
        zmag = r_z[ANGLE_STEPS][ZW-1] ? -r_z[ANGLE_STEPS] : r_z[ANGLE_STEPS];
        mag  = zmag[ZW-2:FRAC_BITS];
        if (r_zero[ANGLE_STEPS]) begin
            n_deg = FULL_TURN_DEG;
        end else if (r_z[ANGLE_STEPS][ZW-1]) begin
            n_deg = FULL_TURN_DEG - mag;
        end else if (mag == 9'd0) begin
            n_deg = FULL_TURN_DEG;
        end else begin
            n_deg = mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deg_vld <= 1'b0;
        end else begin
            r_deg_vld <= r_vld[ANGLE_STEPS];
        end
        r_deg <= n_deg;
    end

    // Last decimal digit through a reciprocal multiply
    always_comb begin
        prod   = {8'd0, r_deg} * {9'd0, RECIP10};
        quot   = prod[16:RECIP10_SHFT];
        quot10 = {3'd0, quot} * 9'd10;
        digit  = 4'(r_deg - quot10);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= r_deg_vld;
        end
        o_heading_deg    <= r_deg;
        o_digit_segments <= digit_to_segments(digit);
    end

endmodule

// ===== sv/chss_checker.sv =====
module chss_checker #(
    parameter int ANGLE_STEPS = 24
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic signed [15:0] i_mag_x,
    input logic signed [15:0] i_mag_y,
    input logic               o_strobe,
    input logic [8:0]         o_heading_deg,
    input logic [6:0]         o_digit_segments
);

    localparam int LAT = ANGLE_STEPS + 3;

    logic beat_in;
    assign beat_in = start && !busy;

    // Heading stays inside one turn
    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_heading_deg >= 9'd1) && (o_heading_deg <= 9'd360))
        else $error("heading out of range");

    // Every result beat traces back to an input beat at fixed latency
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(beat_in, LAT))
        else $error("result without input beat");

    // Every input beat yields a result beat at fixed latency
    a_no_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        beat_in |-> ##LAT o_strobe)
        else $error("input beat lost");

    // A zero field reads as a full turn, digit zero
    a_zero_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (beat_in && (i_mag_x == 16'sd0) && (i_mag_y == 16'sd0)) |->
            ##LAT ((o_heading_deg == 9'd360) && (o_digit_segments == 7'h40)))
        else $error("zero field not mapped to 360");

endmodule

bind compass_heading_seven_segment chss_checker #(
    .ANGLE_STEPS(ANGLE_STEPS)
) u_chss_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .i_mag_x          (i_mag_x),
    .i_mag_y          (i_mag_y),
    .o_strobe         (o_strobe),
    .o_heading_deg    (o_heading_deg),
    .o_digit_segments (o_digit_segments)
);

// ===== bench/compass_heading_checker.sv =====
module compass_heading_checker
    import chss_pkg::*;
#(
    parameter int ANGLE_STEPS = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic signed [15:0] i_mag_x,
    input  logic signed [15:0] i_mag_y,
    input  logic               o_strobe,
    input  logic [8:0]         o_heading_deg,
    input  logic [6:0]         o_digit_segments,
    output int                 pending_count,
    output int                 error_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] UNIT_Q46 = 64'd1 << 46;
    localparam logic [63:0] QUARTER_PI_Q46 = 64'h00C9_0FDA_A221_68C2 >> 10;

    typedef struct packed {
        t_deg       deg;
        logic [6:0] segs;
    } t_heading;

    logic signed [63:0] micro_angle [ANGLE_STEPS];
    logic signed [63:0] half_turn_q32;
    t_heading           expected_headings [$];
    int                 mismatch_total = 0;

    // radians in Q46 to scaled degrees in Q32, rounded
    function automatic logic [63:0] rad_q46_to_deg_q32(input logic [63:0] rad);
        logic [63:0] scaled;
        scaled = (rad * 64'd75000) / 64'd1309;
        return (scaled + (64'd1 << 13)) >> 14;
    endfunction

    // atan(2^-i) in Q46 from the truncated alternating series
    function automatic logic [63:0] atan_series_q46(input int i);
        logic [63:0] sum;
        int          sh;
        sum = 64'd0;
        if (i == 0) return QUARTER_PI_Q46;
        for (int k = 0; k < 64; k++) begin
            sh = i * (2 * k + 1);
            if (sh > 46) break;
            if (k % 2 == 1) sum = sum - (UNIT_Q46 >> sh) / 64'(2 * k + 1);
            else sum = sum + (UNIT_Q46 >> sh) / 64'(2 * k + 1);
        end
        return sum;
    endfunction

    initial begin
        for (int i = 0; i < ANGLE_STEPS; i++)
            micro_angle[i] = rad_q46_to_deg_q32(atan_series_q46(i));
        half_turn_q32 = rad_q46_to_deg_q32(QUARTER_PI_Q46 << 2);
    end

    function automatic t_heading predict_heading(input logic signed [15:0] mx,
                                                 input logic signed [15:0] my);
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] z;
        logic signed [63:0] dx;
        logic signed [63:0] dy;
        logic signed [63:0] deg;
        t_heading           r;
        x = mx;
        y = my;
        z = 0;
        if (x == 0 && y == 0) begin
            deg = 0;
        end else begin
            // fold the left half plane onto the right one
            if (x < 0) begin
                z = (y >= 0) ? half_turn_q32 : -half_turn_q32;
                x = -x;
                y = -y;
            end
            x = x <<< 32;
            y = y <<< 32;
            for (int i = 0; i < ANGLE_STEPS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0) begin
                    x = x + dx;
                    y = y - dy;
                    z = z + micro_angle[i];
                end else begin
                    x = x - dx;
                    y = y + dy;
                    z = z - micro_angle[i];
                end
            end
            // truncate toward zero
            if (z >= 0) deg = z >>> 32;
            else deg = -((-z) >>> 32);
        end
        if (deg <= 0) deg = deg + 360;
        r.deg = deg[8:0];
        case (deg % 10)
            0:       r.segs = ~7'h3F;
            1:       r.segs = ~7'h06;
            2:       r.segs = ~7'h5B;
            3:       r.segs = ~7'h4F;
            4:       r.segs = ~7'h66;
            5:       r.segs = ~7'h6D;
            6:       r.segs = ~7'h7D;
            7:       r.segs = ~7'h07;
            8:       r.segs = ~7'h7F;
            default: r.segs = ~7'h6F;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_heading want;
        if (i_rst_n) begin
            if (o_strobe) begin
                if (expected_headings.size() == 0) begin
                    $error("o_strobe with no heading pending: deg %0d segs %02h",
                           o_heading_deg, o_digit_segments);
                    mismatch_total++;
                end else begin
                    want = expected_headings.pop_front();
                    if (o_heading_deg !== want.deg) begin
                        $error("heading_deg: expected %0d, got %0d",
                               want.deg, o_heading_deg);
                        mismatch_total++;
                    end
                    if (o_digit_segments !== want.segs) begin
                        $error("digit_segments: expected %02h, got %02h",
                               want.segs, o_digit_segments);
                        mismatch_total++;
                    end
                end
            end
            if (start && !busy)
                expected_headings.push_back(predict_heading(i_mag_x, i_mag_y));
        end
        pending_count <= expected_headings.size();
        error_count   <= mismatch_total;
    end

endmodule

// ===== bench/tb_compass_heading_seven_segment.sv =====
module tb_compass_heading_seven_segment;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ANGLE_STEPS = 24;
    localparam int RANDOM_BEATS = 850;
    localparam int CYCLE_LIMIT = 200000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [15:0] i_mag_x = '0;
    logic signed [15:0] i_mag_y = '0;
    logic               o_strobe;
    logic [8:0]         o_heading_deg;
    logic [6:0]         o_digit_segments;
    int                 pending_count;
    int                 error_count;
    int                 cycle_count = 0;

    compass_heading_seven_segment #(
        .ANGLE_STEPS(ANGLE_STEPS)
    ) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_mag_x          (i_mag_x),
        .i_mag_y          (i_mag_y),
        .o_strobe         (o_strobe),
        .o_heading_deg    (o_heading_deg),
        .o_digit_segments (o_digit_segments)
    );

    compass_heading_checker #(
        .ANGLE_STEPS(ANGLE_STEPS)
    ) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_mag_x          (i_mag_x),
        .i_mag_y          (i_mag_y),
        .o_strobe         (o_strobe),
        .o_heading_deg    (o_heading_deg),
        .o_digit_segments (o_digit_segments),
        .pending_count    (pending_count),
        .error_count      (error_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // present one sample and hold it until the block takes the beat
    task automatic send_sample(input logic signed [15:0] x, input logic signed [15:0] y);
        @(negedge i_clk);
        start   <= 1'b1;
        i_mag_x <= x;
        i_mag_y <= y;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain_headings();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_count != 0) @(posedge i_clk);
    endtask

    task automatic random_sample(output logic signed [15:0] x,
                                 output logic signed [15:0] y);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
                x = 16'($urandom);
                y = 16'($urandom);
            end
            6, 7: begin
                x = 16'(int'($urandom_range(0, 40)) - 20);
                y = 16'(int'($urandom_range(0, 40)) - 20);
            end
            8: begin
                // one axis at zero or at an extreme
                x = $urandom_range(0, 1) ? 16'sh7FFF : -16'sh8000;
                y = 16'($urandom);
                if ($urandom_range(0, 1)) x = '0;
                if ($urandom_range(0, 3) == 0) begin
                    x = 16'($urandom);
                    y = '0;
                end
            end
            default: begin
                // near the 360 and 180 seams
                x = 16'($urandom) | 16'h4000;
                if ($urandom_range(0, 1)) x[15] = 1'b1;
                else x[15] = 1'b0;
                y = 16'(int'($urandom_range(0, 600)) - 300);
            end
        endcase
    endtask

    initial begin
        logic signed [15:0] x;
        logic signed [15:0] y;
        int                 sent;
        int                 burst;
        bit                 paused;
        sent   = 0;
        paused = 1'b0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_sample(16'sd0, 16'sd0);
        send_sample(16'sd1, 16'sd0);
        send_sample(16'sd0, 16'sd1);
        send_sample(-16'sd1, 16'sd0);
        send_sample(16'sd0, -16'sd1);
        send_sample(16'sd1, 16'sd1);
        send_sample(-16'sd1, 16'sd1);
        send_sample(-16'sd1, -16'sd1);
        send_sample(16'sd1, -16'sd1);
        send_sample(16'sh7FFF, 16'sd0);
        send_sample(-16'sh8000, 16'sd0);
        send_sample(16'sd0, 16'sh7FFF);
        send_sample(16'sd0, -16'sh8000);
        send_sample(16'sh7FFF, 16'sh7FFF);
        send_sample(-16'sh8000, -16'sh8000);
        send_sample(-16'sh8000, 16'sh7FFF);
        send_sample(16'sh7FFF, -16'sh8000);
        send_sample(-16'sh8000, 16'sd1);
        send_sample(-16'sh8000, -16'sd1);
        send_sample(16'sh7FFF, -16'sd1);
        send_sample(16'sh7FFF, 16'sd1);
        send_sample(-16'sd5, 16'sd0);
        send_sample(16'sd100, 16'sd173);
        drain_headings();

        while (sent < RANDOM_BEATS) begin
            burst = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 12);
            repeat (burst) begin
                random_sample(x, y);
                send_sample(x, y);
                sent++;
            end
            if (!paused && sent >= RANDOM_BEATS / 2) begin
                paused = 1'b1;
                drain_headings();
            end else if ($urandom_range(0, 3) != 0) begin
                idle_cycles($urandom_range(1, 8));
            end
        end

        drain_headings();
        repeat (ANGLE_STEPS + 10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/chss_pkg.sv
sv/compass_heading_seven_segment.sv
sv/chss_checker.sv
bench/compass_heading_checker.sv
bench/tb_compass_heading_seven_segment.sv
